// ===== design/crsf_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// crsf_pkg
// Shared types, status codes and the CRC-8 step for the CRSF frame parser.
// -----------------------------------------------------------------------------
package crsf_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned PLEN_W = 6;
	localparam int unsigned CNT_W  = 32;
	localparam int unsigned POS_W  = 7;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;
	localparam logic [BYTE_W-1:0] LEN_LOW  = 8'd2;
	localparam logic [BYTE_W-1:0] LEN_HIGH = 8'd62;

	typedef logic [1:0] status_t;

	localparam status_t ST_NONE   = 2'd0;
	localparam status_t ST_OK     = 2'd1;
	localparam status_t ST_BADLEN = 2'd2;
	localparam status_t ST_BADCRC = 2'd3;

	// One parsed byte's outcome, handed to the drain sequencer.
	typedef struct packed {
		status_t             status;
		logic [BYTE_W-1:0]   address;
		logic [BYTE_W-1:0]   frame_type;
		logic [PLEN_W-1:0]   payload_count;
		logic [CNT_W-1:0]    good_frames;
		logic [CNT_W-1:0]    crc_fails;
		logic [CNT_W-1:0]    length_fails;
	} crsf_job_t;

	// CRC-8/DVB-S2: MSB first, no reflection, no final xor.
	function automatic logic [BYTE_W-1:0] crc_fold(input logic [BYTE_W-1:0] crc,
	                                               input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== design/crsf_payload_ram.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// crsf_payload_ram
// Single-port-write, single-port-read payload store with registered read data.
// -----------------------------------------------------------------------------
module crsf_payload_ram #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [7:0]               wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [7:0]               rd_data
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold read data between reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== design/crsf_drain.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// crsf_drain
// Result sequencer: expands a parsed outcome into results, reads the payload
// store one entry per cycle unless stalled and feeds a registered output stage.
// -----------------------------------------------------------------------------
module crsf_drain #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     load,
	input  wire crsf_pkg::crsf_job_t      job,
	output logic                          busy,
	output logic                          rd_en,
	output logic [$clog2(DEPTH)-1:0]      rd_addr,
	input  wire logic [7:0]               rd_data,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output crsf_pkg::status_t             status,
	output logic [7:0]                    address,
	output logic [7:0]                    frame_type,
	output logic [5:0]                    payload_count,
	output logic [7:0]                    payload_byte,
	output logic [5:0]                    payload_pos,
	output logic                          last,
	output logic [31:0]                   good_frames,
	output logic [31:0]                   crc_fails,
	output logic [31:0]                   length_fails
);
	import crsf_pkg::*;

	logic              act_q;
	crsf_job_t         job_q;
	logic [PLEN_W-1:0] idx_q;

	logic              vld_s2;
	crsf_job_t         job_s2;
	logic [PLEN_W-1:0] pos_s2;
	logic              last_s2;
	logic              ram_s2;

	logic              out_vld_q;
	logic              move;
	logic              issue;
	logic              is_last;
	logic              use_ram;

	assign move    = vld_s2 && (!out_vld_q || !out_stall);
	assign issue   = act_q && (!vld_s2 || move);
	assign use_ram = (job_q.status == ST_OK) && (job_q.payload_count != '0);
	assign is_last = !use_ram || ((idx_q + PLEN_W'(1)) == job_q.payload_count);

	assign busy    = act_q;
	assign rd_en   = issue && use_ram;
	assign rd_addr = idx_q[$clog2(DEPTH)-1:0];

	// Sequencer: one result issued per free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (load) begin
			act_q <= 1'b1;
		end else if (issue && is_last) begin
			act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
			idx_q <= '0;
		end else if (issue) begin
			idx_q <= idx_q + PLEN_W'(1);
		end
	end

	// Read stage: waits for the registered RAM data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (issue) begin
			vld_s2 <= 1'b1;
		end else if (move) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			job_s2  <= job_q;
			pos_s2  <= use_ram ? idx_q : '0;
			last_s2 <= is_last;
			ram_s2  <= use_ram;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (move) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			status        <= job_s2.status;
			address       <= job_s2.address;
			frame_type    <= job_s2.frame_type;
			payload_count <= job_s2.payload_count;
			payload_byte  <= ram_s2 ? rd_data : 8'd0;
			payload_pos   <= pos_s2;
			last          <= last_s2;
			good_frames   <= job_s2.good_frames;
			crc_fails     <= job_s2.crc_fails;
			length_fails  <= job_s2.length_fails;
		end
	end

	assign out_valid = out_vld_q;

endmodule
`default_nettype wire

// ===== design/crsf_frame_parser_top.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// crsf_frame_parser_top
// Byte-serial CRSF frame receiver with CRC-8/DVB-S2 check and payload replay.
// -----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | sink      | in_valid / in_stall  | data_byte
//  out     | source    | out_valid / out_stall| status, address, frame_type,
//          |           |                      | payload_count, payload_byte,
//          |           |                      | payload_pos, last, good_frames,
//          |           |                      | crc_fails, length_fails
//
//  Each accepted byte is parsed in its accepting cycle; its first result
//  passes the sequencer register, read stage and output register to out_valid.
//  in_stall then holds until every result of the byte is issued: one for
//  most bytes and payload_count for a good frame with a payload.
//  arst_n clears position, CRC, header and counters; the payload store is
//  not cleared, as only entries written in the current frame are read back.
// -----------------------------------------------------------------------------
module crsf_frame_parser_top #(
	parameter int unsigned FRAME_MAX  = 64,
	parameter int unsigned COUNT_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    data_byte,
	output logic               out_valid,
	input  wire logic          out_stall,
	output crsf_pkg::status_t  status,
	output logic [7:0]         address,
	output logic [7:0]         frame_type,
	output logic [5:0]         payload_count,
	output logic [7:0]         payload_byte,
	output logic [5:0]         payload_pos,
	output logic               last,
	output logic [31:0]        good_frames,
	output logic [31:0]        crc_fails,
	output logic [31:0]        length_fails
);
	import crsf_pkg::*;

	localparam int unsigned AW = $clog2(FRAME_MAX);

	// Parser state
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      tot_q;
	logic [BYTE_W-1:0]     addr_q;
	logic [BYTE_W-1:0]     type_q;
	logic [PLEN_W-1:0]     plen_q;
	logic [BYTE_W-1:0]     crc_q;
	logic [COUNT_BITS-1:0] good_q;
	logic [COUNT_BITS-1:0] crcf_q;
	logic [COUNT_BITS-1:0] lenf_q;

	logic [POS_W-1:0]      pos_d;
	logic [POS_W-1:0]      tot_d;
	logic [BYTE_W-1:0]     addr_d;
	logic [BYTE_W-1:0]     type_d;
	logic [PLEN_W-1:0]     plen_d;
	logic [BYTE_W-1:0]     crc_d;
	logic [COUNT_BITS-1:0] good_d;
	logic [COUNT_BITS-1:0] crcf_d;
	logic [COUNT_BITS-1:0] lenf_d;

	logic                  acc;
	logic                  busy;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [POS_W-1:0]      pay_idx;
	logic [BYTE_W:0]       tot_sum;
	logic [BYTE_W-1:0]     len_rem;
	status_t               st_d;
	crsf_job_t             job;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [7:0]            rd_data;

	// Take a byte only when the sequencer has finished the previous one.
	assign in_stall = busy;
	assign acc      = in_valid && !busy;

	assign pay_idx  = pos_q - POS_W'(3);
	assign wr_addr  = pay_idx[AW-1:0];
	assign tot_sum  = {1'b0, data_byte} + 9'd2;
	assign len_rem  = data_byte - LEN_LOW;

	// Parse one byte against the current frame position.
	always_comb begin
		pos_d  = pos_q;
		tot_d  = tot_q;
		addr_d = addr_q;
		type_d = type_q;
		plen_d = plen_q;
		crc_d  = crc_q;
		good_d = good_q;
		crcf_d = crcf_q;
		lenf_d = lenf_q;
		st_d   = ST_NONE;
		wr_en  = 1'b0;
		priority if (pos_q == '0) begin
			// address byte
			addr_d = data_byte;
			pos_d  = POS_W'(1);
		end else if (pos_q == POS_W'(1)) begin
			// length byte: drop it and restart if implausible
			if (data_byte < LEN_LOW || data_byte > LEN_HIGH) begin
				pos_d  = '0;
				tot_d  = '0;
				lenf_d = lenf_q + COUNT_BITS'(1);
				st_d   = ST_BADLEN;
			end else begin
				plen_d = len_rem[PLEN_W-1:0];
				tot_d  = tot_sum[POS_W-1:0];
				crc_d  = '0;
				pos_d  = POS_W'(2);
			end
		end else if (pos_q >= POS_W'(FRAME_MAX)) begin
			// frame overrun
			pos_d  = '0;
			tot_d  = '0;
			lenf_d = lenf_q + COUNT_BITS'(1);
			st_d   = ST_BADLEN;
		end else if ((pos_q + POS_W'(1)) < tot_q) begin
			// type or payload byte: fold into the CRC
			crc_d = crc_fold(crc_q, data_byte);
			if (pos_q == POS_W'(2)) begin
				type_d = data_byte;
			end else begin
				wr_en = 1'b1;
			end
			pos_d = pos_q + POS_W'(1);
		end else begin
			// CRC byte closes the frame
			pos_d = '0;
			tot_d = '0;
			if (data_byte != crc_q) begin
				crcf_d = crcf_q + COUNT_BITS'(1);
				st_d   = ST_BADCRC;
			end else begin
				good_d = good_q + COUNT_BITS'(1);
				st_d   = ST_OK;
			end
		end
	end

	// Header fields only travel with a good frame.
	always_comb begin
		job.status        = st_d;
		job.address       = (st_d == ST_OK) ? addr_q : '0;
		job.frame_type    = (st_d == ST_OK) ? type_q : '0;
		job.payload_count = (st_d == ST_OK) ? plen_q : '0;
		job.good_frames   = CNT_W'(good_d);
		job.crc_fails     = CNT_W'(crcf_d);
		job.length_fails  = CNT_W'(lenf_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tot_q  <= '0;
			addr_q <= '0;
			type_q <= '0;
			plen_q <= '0;
			crc_q  <= '0;
			good_q <= '0;
			crcf_q <= '0;
			lenf_q <= '0;
		end else if (acc) begin
			pos_q  <= pos_d;
			tot_q  <= tot_d;
			addr_q <= addr_d;
			type_q <= type_d;
			plen_q <= plen_d;
			crc_q  <= crc_d;
			good_q <= good_d;
			crcf_q <= crcf_d;
			lenf_q <= lenf_d;
		end
	end

	crsf_payload_ram #(
		.DEPTH (FRAME_MAX)
	) u_ram (
		.clk     (clk),
		.wr_en   (acc && wr_en),
		.wr_addr (wr_addr),
		.wr_data (data_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	crsf_drain #(
		.DEPTH (FRAME_MAX)
	) u_drain (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (acc),
		.job           (job),
		.busy          (busy),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.address       (address),
		.frame_type    (frame_type),
		.payload_count (payload_count),
		.payload_byte  (payload_byte),
		.payload_pos   (payload_pos),
		.last          (last),
		.good_frames   (good_frames),
		.crc_fails     (crc_fails),
		.length_fails  (length_fails)
	);

endmodule
`default_nettype wire

// ===== tb/tb_crsf_frame_parser_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_crsf_frame_parser_top
// Self-checking bench for the CRSF frame parser. It streams good, corrupted
// and malformed frames byte by byte and checks every output transaction
// against a behavioural model of the parser, under random idling on both
// channels and a long output hold-off.
// -----------------------------------------------------------------------------
module tb_crsf_frame_parser_top;
	import crsf_pkg::*;

	// Generous cycle ceiling: a few hundred bytes, under two results per byte
	// on average, random stalls and one long hold-off fit many times over.
	localparam int unsigned LIMIT_CYCLES   = 500000;
	localparam int unsigned RANDOM_BYTES   = 20;
	localparam int unsigned IDLE_PCT       = 36;
	localparam int unsigned HOLDOFF_CYCLES = 300;
	// Allow a margin on top of the pipeline before calling the run done.
	localparam int unsigned DRAIN_CYCLES   = 16;
	localparam int unsigned FRAME_LIMIT    = 64;
	localparam int unsigned MAX_PAYLOAD    = 60;

	// One expected output transaction.
	typedef struct packed {
		status_t     status;
		logic [7:0]  address;
		logic [7:0]  frame_type;
		logic [5:0]  payload_count;
		logic [7:0]  payload_byte;
		logic [5:0]  payload_pos;
		logic        last;
		logic [31:0] good_frames;
		logic [31:0] crc_fails;
		logic [31:0] length_fails;
	} outcome_t;

	// Clock, reset and block ports; every input is known from time zero.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	status_t     status;
	logic [7:0]  address;
	logic [7:0]  frame_type;
	logic [5:0]  payload_count;
	logic [7:0]  payload_byte;
	logic [5:0]  payload_pos;
	logic        last;
	logic [31:0] good_frames;
	logic [31:0] crc_fails;
	logic [31:0] length_fails;

	// Parser model state: frame position, header, running CRC and counters.
	logic [6:0]  frame_pos;
	logic [6:0]  frame_total;
	logic [7:0]  held_addr;
	logic [7:0]  held_len;
	logic [7:0]  held_kind;
	logic [7:0]  crc_acc;
	logic [7:0]  payload_mem [0:63];
	logic [31:0] n_good;
	logic [31:0] n_crc_bad;
	logic [31:0] n_len_bad;

	// Results still owed by the block, oldest first.
	outcome_t    outcome_q [$];
	// Payload of the next frame to be sent.
	logic [7:0]  frame_body [$];

	bit          calm         = 1'b0;
	int unsigned holdoff_req  = 0;
	int unsigned bytes_sent   = 0;
	int unsigned checked      = 0;
	int unsigned fail_count   = 0;
	int unsigned cycle_count  = 0;

	always #1 clk = ~clk;

	crsf_frame_parser_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.address       (address),
		.frame_type    (frame_type),
		.payload_count (payload_count),
		.payload_byte  (payload_byte),
		.payload_pos   (payload_pos),
		.last          (last),
		.good_frames   (good_frames),
		.crc_fails     (crc_fails),
		.length_fails  (length_fails)
	);

	// ---------------------------------------------------------------------
	// Behavioural model
	// ---------------------------------------------------------------------

	// CRC-8, polynomial 0xD5, MSB first: fold one byte into the accumulator.
	function automatic logic [7:0] crc8_d5(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

	// Build one result carrying the counters as they stand now.
	function automatic outcome_t make_outcome(input status_t st, input logic [7:0] a,
	                                          input logic [7:0] t, input logic [5:0] pl,
	                                          input logic [7:0] pb, input logic [5:0] pp,
	                                          input logic lst);
		outcome_t o;
		o.status        = st;
		o.address       = a;
		o.frame_type    = t;
		o.payload_count = pl;
		o.payload_byte  = pb;
		o.payload_pos   = pp;
		o.last          = lst;
		o.good_frames   = n_good;
		o.crc_fails     = n_crc_bad;
		o.length_fails  = n_len_bad;
		return o;
	endfunction

	// Advance the parser model by one accepted byte and queue what it owes.
	function automatic void crsf_parse_byte(input logic [7:0] b);
		int unsigned plen;
		if (frame_pos == 7'd0) begin
			held_addr = b;
			frame_pos = 7'd1;
			outcome_q.push_back(make_outcome(ST_NONE, 8'h00, 8'h00, 6'd0, 8'h00, 6'd0, 1'b1));
		end else if (frame_pos == 7'd1) begin
			if (b < LEN_LOW || b > LEN_HIGH) begin
				// Implausible length: drop it and restart at the address.
				frame_pos   = 7'd0;
				frame_total = 7'd0;
				n_len_bad   = n_len_bad + 32'd1;
				outcome_q.push_back(make_outcome(ST_BADLEN, 8'h00, 8'h00, 6'd0, 8'h00,
				                                 6'd0, 1'b1));
			end else begin
				held_len    = b;
				frame_total = 7'(b + 8'd2);
				crc_acc     = 8'h00;
				frame_pos   = 7'd2;
				outcome_q.push_back(make_outcome(ST_NONE, 8'h00, 8'h00, 6'd0, 8'h00,
				                                 6'd0, 1'b1));
			end
		end else if (int'(frame_pos) >= FRAME_LIMIT) begin
			// Frame overrun: only reachable with a shorter frame limit.
			frame_pos   = 7'd0;
			frame_total = 7'd0;
			n_len_bad   = n_len_bad + 32'd1;
			outcome_q.push_back(make_outcome(ST_BADLEN, 8'h00, 8'h00, 6'd0, 8'h00, 6'd0, 1'b1));
		end else if (int'(frame_pos) + 1 < int'(frame_total)) begin
			// Type or payload byte: fold into the CRC and keep it.
			crc_acc = crc8_d5(crc_acc, b);
			if (frame_pos == 7'd2) begin
				held_kind = b;
			end else begin
				payload_mem[6'(frame_pos - 7'd3)] = b;
			end
			frame_pos = frame_pos + 7'd1;
			outcome_q.push_back(make_outcome(ST_NONE, 8'h00, 8'h00, 6'd0, 8'h00, 6'd0, 1'b1));
		end else begin
			// CRC byte closes the frame either way.
			frame_pos   = 7'd0;
			frame_total = 7'd0;
			if (b != crc_acc) begin
				n_crc_bad = n_crc_bad + 32'd1;
				outcome_q.push_back(make_outcome(ST_BADCRC, 8'h00, 8'h00, 6'd0, 8'h00,
				                                 6'd0, 1'b1));
			end else begin
				n_good = n_good + 32'd1;
				plen   = int'(held_len) - 2;
				if (plen == 0) begin
					outcome_q.push_back(make_outcome(ST_OK, held_addr, held_kind, 6'd0,
					                                 8'h00, 6'd0, 1'b1));
				end else begin
					for (int i = 0; i < plen; i++) begin
						outcome_q.push_back(make_outcome(ST_OK, held_addr, held_kind,
						                                 6'(plen), payload_mem[i], 6'(i),
						                                 i == plen - 1));
					end
				end
			end
		end
	endfunction

	// ---------------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------------

	// Offer one byte, idling first at random, and hold it until accepted.
	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		crsf_parse_byte(b);
		bytes_sent++;
	endtask

	// Fill the next payload with random bytes.
	task automatic fill_body(input int unsigned n);
		frame_body = {};
		repeat (n) frame_body.push_back(8'($urandom_range(255)));
	endtask

	// Send a whole frame around frame_body; optionally spoil its CRC byte.
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] kind, input bit corrupt);
		logic [7:0] crc;
		crc = crc8_d5(8'h00, kind);
		foreach (frame_body[i]) crc = crc8_d5(crc, frame_body[i]);
		if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
		send_byte(addr);
		send_byte(8'(frame_body.size() + 2));
		send_byte(kind);
		foreach (frame_body[i]) send_byte(frame_body[i]);
		send_byte(crc);
	endtask

	// A length byte outside the plausible range, from either side.
	function automatic logic [7:0] bad_length();
		if ($urandom_range(1)) begin
			return 8'($urandom_range(int'(LEN_LOW) - 1));
		end
		return 8'($urandom_range(int'(LEN_HIGH) + 1, 255));
	endfunction

	// Drop valid and hold until every owed result has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Receiver side and checking
	// ---------------------------------------------------------------------

	// Stall at random; a hold-off request is counted down here, cycle by cycle.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (holdoff_req != 0) begin
				hold_left   = holdoff_req;
				holdoff_req = 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
	                                    input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each accepted output transaction with the oldest expectation.
	always @(posedge clk) begin : check_out
		outcome_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (outcome_q.size() == 0) begin
				$error("output transaction with nothing expected: status %0d", status);
				fail_count++;
			end else begin
				want = outcome_q.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("address", 32'(want.address), 32'(address));
				check_field("frame_type", 32'(want.frame_type), 32'(frame_type));
				check_field("payload_count", 32'(want.payload_count), 32'(payload_count));
				check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
				check_field("payload_pos", 32'(want.payload_pos), 32'(payload_pos));
				check_field("last", 32'(want.last), 32'(last));
				check_field("good_frames", want.good_frames, good_frames);
				check_field("crc_fails", want.crc_fails, crc_fails);
				check_field("length_fails", want.length_fails, length_fails);
				checked++;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Field extremes, empty payload, every bad-length side and a bad CRC.
	task automatic test_directed_frames();
		logic [7:0] bad_len [4];
		bad_len = '{8'd0, LEN_LOW - 8'd1, LEN_HIGH + 8'd1, 8'hFF};
		// Empty payload with all-zero header bytes.
		frame_body = {};
		send_frame(8'h00, 8'h00, 1'b0);
		// All-ones header with both payload byte extremes.
		frame_body = {8'h00, 8'hFF};
		send_frame(8'hFF, 8'hFF, 1'b0);
		// Implausible lengths below and above the window.
		foreach (bad_len[i]) begin
			send_byte(8'($urandom_range(255)));
			send_byte(bad_len[i]);
		end
		// Spoilt CRC on a one-byte payload.
		frame_body = {8'hA5};
		send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
	endtask

	// Hold the output off for a long stretch while bytes keep coming, so the
	// block fills and stalls its input; then pause the sender until drained.
	task automatic test_backpressure();
		holdoff_req = HOLDOFF_CYCLES;
		fill_body(MAX_PAYLOAD);
		send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
		repeat (3) begin
			fill_body($urandom_range(0, 4));
			send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
		end
		wait_drained();
		fill_body(2);
		send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
	endtask

	// Mostly well-formed frames with random content; the rest bad CRCs,
	// bad lengths and loose noise followed by a resync to the address.
	task automatic test_random_stream();
		int unsigned start;
		int unsigned done;
		int unsigned pick;
		start = bytes_sent;
		done  = 0;
		while (done < RANDOM_BYTES) begin
			// Keep a stretch in the middle free of idling on either side.
			calm = (done >= RANDOM_BYTES / 4) && (done < 3 * RANDOM_BYTES / 4);
			pick = $urandom_range(99);
			if (pick < 65) begin
				fill_body(($urandom_range(29) == 0) ? MAX_PAYLOAD : $urandom_range(0, 6));
				send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
			end else if (pick < 80) begin
				fill_body($urandom_range(0, 6));
				send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
			end else if (pick < 90) begin
				send_byte(8'($urandom_range(255)));
				send_byte(bad_length());
			end else begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
				// Resync: kill a pending length, or run the frame out.
				while (frame_pos != 7'd0) begin
					if (frame_pos == 7'd1) begin
						send_byte(bad_length());
					end else begin
						send_byte(8'($urandom_range(255)));
					end
				end
			end
			done = bytes_sent - start;
		end
		calm = 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Run control
	// ---------------------------------------------------------------------

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= LIMIT_CYCLES);
		$display("simulation failed");
		$finish;
	end

	initial begin
		// Model comes out of reset with position, header, CRC and counters cleared.
		frame_pos   = 7'd0;
		frame_total = 7'd0;
		held_addr   = 8'h00;
		held_len    = 8'h00;
		held_kind   = 8'h00;
		crc_acc     = 8'h00;
		n_good      = 32'd0;
		n_crc_bad   = 32'd0;
		n_len_bad   = 32'd0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_backpressure();
		test_random_stream();

		// Drop valid, let the owed results out, then give the pipe a margin.
		in_valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("bytes sent %0d, output transactions checked %0d", bytes_sent, checked);
		$display("frames good %0d, crc errors %0d, length errors %0d",
		         n_good, n_crc_bad, n_len_bad);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
